/* rtl/tcae_pkg.sv */
// ----------------------------------------------------------------------------
// tcae_pkg
// Shared types, codes and helpers for the text cursor autowrap engine.
// ----------------------------------------------------------------------------
package tcae_pkg;

  // input command codes
  localparam logic [2:0] CMD_WRITE    = 3'd0;
  localparam logic [2:0] CMD_BREAK    = 3'd1;
  localparam logic [2:0] CMD_MOVE_ABS = 3'd2;
  localparam logic [2:0] CMD_MOVE_REL = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  // overflow modes for a line break on the bottom row
  localparam logic [1:0] OVF_WRAP        = 2'd0;
  localparam logic [1:0] OVF_SHIFT       = 2'd1;
  localparam logic [1:0] OVF_GROW_SHIFT  = 2'd2;
  localparam logic [1:0] OVF_GROW_WRAP   = 2'd3;

  // width of the limit compare for moves, covers the parameter range
  localparam int LIM_W = 13;

  // configuration register indexes (the fill cell is kept by the external store)
  typedef enum logic [2:0] {
    REG_AUTO_WRAP     = 3'd0,
    REG_OVERFLOW_MODE = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_START_HEIGHT  = 3'd3,
    REG_MAX_HEIGHT    = 3'd4
  } cfg_reg_t;

  // classified command, as the front hands it to the back
  typedef enum logic [2:0] {
    K_NOP      = 3'd0,
    K_WRITE    = 3'd1,
    K_BREAK    = 3'd2,
    K_MOVE_ABS = 3'd3,
    K_MOVE_REL = 3'd4,
    K_CLEAR    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       cell_val;
    logic              wide;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
  } cmd_t;

  // result word, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic        wrap_pending_out;
    logic [8:0]  rows_now;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic        clear_all;
    logic        grow_row;
    logic        scroll_up;
    logic [31:0] cell_out;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic        cell_write;
  } res_t;

  typedef struct packed {
    logic [7:0] row;
    logic [8:0] rc;
    logic       scroll;
    logic       grow;
  } lb_t;

  function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] lo,
                                        input logic [8:0] hi);
    logic [8:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // line break from the given row; column and pending wrap go to zero at the caller
  function automatic lb_t line_break(input logic [7:0] row, input logic [8:0] rc,
                                     input logic [8:0] maxh, input logic [1:0] mode);
    lb_t        r;
    logic       can_grow;
    logic [8:0] rc_last;
    r        = '{row: row, rc: rc, scroll: 1'b0, grow: 1'b0};
    can_grow = rc < maxh;
    rc_last  = rc - 9'd1;
    if (({1'b0, row} + 9'd1) < rc) begin
      r.row = row + 8'd1;
    end else begin
      case (mode)
        OVF_WRAP: begin
          r.row = 8'd0;
        end
        OVF_SHIFT: begin
          r.scroll = 1'b1;
          r.row    = rc_last[7:0];
        end
        OVF_GROW_SHIFT: begin
          if (can_grow) begin
            r.rc   = rc + 9'd1;
            r.grow = 1'b1;
            r.row  = rc[7:0];
          end else begin
            r.scroll = 1'b1;
            r.row    = rc_last[7:0];
          end
        end
        OVF_GROW_WRAP: begin
          if (can_grow) begin
            r.rc   = rc + 9'd1;
            r.grow = 1'b1;
            r.row  = rc[7:0];
          end else begin
            r.row = 8'd0;
          end
        end
        default: begin
          r.row = 8'd0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/tcae_front.sv */
// ----------------------------------------------------------------------------
// tcae_front
// Accepts command words, turns the ones that change nothing into no-ops and
// registers the classified command toward the queue.
// ----------------------------------------------------------------------------
module tcae_front #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [55:0]     in_tdata,
  input  logic [2:0]      in_tuser,
  output logic            push,
  output tcae_pkg::cmd_t  push_cmd,
  input  logic            q_ready
);

  localparam int LIM_W = tcae_pkg::LIM_W;

  logic              fv_r;
  tcae_pkg::cmd_t    fcmd_r;
  tcae_pkg::cmd_t    dec;
  logic [1:0]        cw;
  logic signed [9:0] mx;
  logic signed [9:0] my;
  logic [10:0]       ax;
  logic [10:0]       ay;
  logic              move_ok;

  assign cw = in_tdata[33:32];
  assign mx = in_tdata[43:34];
  assign my = in_tdata[53:44];

  always_comb begin
    ax = mx[9] ? (11'd0 - {mx[9], mx}) : {1'b0, mx};
    ay = my[9] ? (11'd0 - {my[9], my}) : {1'b0, my};
    move_ok = ({2'b0, ax} <= LIM_W'(MAX_COLS)) && ({2'b0, ay} <= LIM_W'(MAX_ROWS))
              && !(mx == 10'sd0 && my == 10'sd0);
    dec.cell_val = in_tdata[31:0];
    dec.wide     = (cw == 2'd2);
    dec.dx       = mx;
    dec.dy       = my;
    case (in_tuser)
      tcae_pkg::CMD_WRITE:    dec.kind = (cw == 2'd1 || cw == 2'd2) ? tcae_pkg::K_WRITE
                                                                    : tcae_pkg::K_NOP;
      tcae_pkg::CMD_BREAK:    dec.kind = tcae_pkg::K_BREAK;
      tcae_pkg::CMD_MOVE_ABS: dec.kind = move_ok ? tcae_pkg::K_MOVE_ABS : tcae_pkg::K_NOP;
      tcae_pkg::CMD_MOVE_REL: dec.kind = move_ok ? tcae_pkg::K_MOVE_REL : tcae_pkg::K_NOP;
      tcae_pkg::CMD_CLEAR:    dec.kind = tcae_pkg::K_CLEAR;
      default:                dec.kind = tcae_pkg::K_NOP;
    endcase
  end

  assign in_tready = !fv_r || q_ready;
  assign push      = fv_r && q_ready;
  assign push_cmd  = fcmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      fv_r <= 1'b1;
    end else if (q_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fcmd_r <= dec;
    end
  end

endmodule

/* rtl/tcae_queue.sv */
// ----------------------------------------------------------------------------
// tcae_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcae_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcae_pkg::cmd_t  push_cmd,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output tcae_pkg::cmd_t  q_cmd
);

  tcae_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/tcae_back.sv */
// ----------------------------------------------------------------------------
// tcae_back
// Holds the cursor, row count and settings, carries out one command per
// cycle while the result output is not stalled and registers the result word.
// ----------------------------------------------------------------------------
module tcae_back #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tcae_pkg::cmd_t  q_cmd,
  output logic            pop,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [79:0]     out_tdata
);

  localparam logic [8:0] COL_LIM = 9'(MAX_COLS < 256 ? MAX_COLS : 256);
  localparam logic [8:0] ROW_LIM = 9'(MAX_ROWS < 256 ? MAX_ROWS : 256);
  localparam logic [8:0] WIDTH_RST = tcae_pkg::clamp9(9'd80, 9'd2, COL_LIM);
  localparam logic [8:0] ROWS_RST  = tcae_pkg::clamp9(9'd25, 9'd1, ROW_LIM);

  // settings
  logic       aw_r;
  logic [1:0] mode_r;
  logic [8:0] width_r;
  logic [8:0] maxh_r;

  // cursor state
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic       wp_r, wp_nxt;
  logic [8:0] rc_r, rc_nxt;

  logic              ov_r;
  tcae_pkg::res_t    res_r;
  tcae_pkg::res_t    res;
  tcae_pkg::lb_t     lb;

  logic [7:0]         ex_col, ex_row;
  logic               ex_wp;
  logic [8:0]         ex_rc;
  logic [8:0]         wmax;
  logic               resolve;
  logic               go;
  logic [8:0]         x;
  logic signed [11:0] tx, ty;
  logic [8:0]         h_new;
  logic [8:0]         h_last;

  assign pop        = q_valid && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = res_r;

  assign wmax = width_r - 9'd1;
  assign lb   = tcae_pkg::line_break(row_r, rc_r, maxh_r, mode_r);

  always_comb begin
    ex_col  = col_r;
    ex_row  = row_r;
    ex_wp   = wp_r;
    ex_rc   = rc_r;
    res     = '0;
    resolve = wp_r || ({1'b0, col_r} >= width_r);
    go      = 1'b0;
    x       = '0;
    tx      = '0;
    ty      = '0;
    h_last  = rc_r - 9'd1;
    case (q_cmd.kind)
      tcae_pkg::K_WRITE: begin
        // at most one line break: either a pending wrap or a wide cell on the edge
        if (aw_r && (resolve || ({1'b0, col_r} == wmax && q_cmd.wide))) begin
          ex_col = 8'd0;
          ex_row = lb.row;
          ex_rc  = lb.rc;
          res.scroll_up = lb.scroll;
          res.grow_row  = lb.grow;
        end else if (resolve) begin
          ex_col = wmax[7:0];
        end
        ex_wp = 1'b0;
        go = !(!aw_r && {1'b0, ex_col} == wmax && q_cmd.wide);
        if (go) begin
          res.cell_write = 1'b1;
          res.cell_col   = ex_col;
          res.cell_row   = ex_row;
          res.cell_out   = q_cmd.cell_val;
          if ({1'b0, ex_col} == wmax) begin
            ex_wp = aw_r;
          end else begin
            x = {1'b0, ex_col} + (q_cmd.wide ? 9'd2 : 9'd1);
            if (x >= width_r) begin
              ex_col = wmax[7:0];
              ex_wp  = aw_r;
            end else begin
              ex_col = x[7:0];
            end
          end
        end
      end
      tcae_pkg::K_BREAK: begin
        ex_col = 8'd0;
        ex_row = lb.row;
        ex_rc  = lb.rc;
        ex_wp  = 1'b0;
        res.scroll_up = lb.scroll;
        res.grow_row  = lb.grow;
      end
      tcae_pkg::K_MOVE_ABS, tcae_pkg::K_MOVE_REL: begin
        ex_wp = 1'b0;
        tx = {{2{q_cmd.dx[9]}}, q_cmd.dx};
        ty = {{2{q_cmd.dy[9]}}, q_cmd.dy};
        if (q_cmd.kind == tcae_pkg::K_MOVE_REL) begin
          tx = tx + $signed({4'b0, col_r});
          ty = ty + $signed({4'b0, row_r});
        end
        if (tx < 12'sd0)                        ex_col = 8'd0;
        else if (tx >= $signed({3'b0, width_r})) ex_col = wmax[7:0];
        else                                    ex_col = tx[7:0];
        if (ty < 12'sd0)                      ex_row = 8'd0;
        else if (ty >= $signed({3'b0, rc_r})) ex_row = h_last[7:0];
        else                                  ex_row = ty[7:0];
      end
      tcae_pkg::K_CLEAR: begin
        res.clear_all = 1'b1;
        ex_col = 8'd0;
        ex_row = 8'd0;
        ex_wp  = 1'b0;
      end
      default: begin
      end
    endcase
    res.cursor_col       = ex_col;
    res.cursor_row       = ex_row;
    res.rows_now         = ex_rc;
    res.wrap_pending_out = ex_wp;
  end

  // state update: a command, or a start height write in a cycle that takes no command
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    wp_nxt  = wp_r;
    rc_nxt  = rc_r;
    h_new   = tcae_pkg::clamp9(cfg_data[8:0], 9'd1, ROW_LIM);
    if (pop) begin
      col_nxt = ex_col;
      row_nxt = ex_row;
      wp_nxt  = ex_wp;
      rc_nxt  = ex_rc;
    end else if (cfg_valid && cfg_index == tcae_pkg::REG_START_HEIGHT) begin
      rc_nxt = h_new;
      if ({1'b0, row_r} >= h_new) row_nxt = 8'(h_new - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
      wp_r  <= 1'b0;
      rc_r  <= ROWS_RST;
      ov_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      wp_r  <= wp_nxt;
      rc_r  <= rc_nxt;
      if (pop) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r    <= 1'b1;
      mode_r  <= tcae_pkg::OVF_WRAP;
      width_r <= WIDTH_RST;
      maxh_r  <= ROWS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcae_pkg::REG_AUTO_WRAP:     aw_r    <= cfg_data[0];
        tcae_pkg::REG_OVERFLOW_MODE: mode_r  <= cfg_data[1:0];
        tcae_pkg::REG_SCREEN_WIDTH:  width_r <= tcae_pkg::clamp9(cfg_data[8:0], 9'd2, COL_LIM);
        tcae_pkg::REG_MAX_HEIGHT:    maxh_r  <= tcae_pkg::clamp9(cfg_data[8:0], 9'd1, ROW_LIM);
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/text_cursor_autowrap_engine_core.sv */
// ----------------------------------------------------------------------------
// text_cursor_autowrap_engine_core
// Text-mode cursor engine with auto-wrap, scroll and grow at the bottom row.
// ----------------------------------------------------------------------------
// Takes one command word per clock unless stalled and gives exactly one result
// word for each, through the front register, the queue and the result register. The
// front classifies commands and registers them into a two-entry queue; the back
// updates cursor and row count as it pops each command, which sets the sustained
// rate of one command per clock while the output is not stalled. The fill cell
// is kept by the external cell store: a write to its register index is taken
// and has no effect here. Configuration is always accepted and must be written
// only while the engine is idle.
module text_cursor_autowrap_engine_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_value[31:0], cell_width[33:32], move_x[43:34], move_y[53:44], zero pad
  input  logic [55:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_write[0], cell_col[8:1], cell_row[16:9], cell_out[48:17], scroll_up[49],
  // grow_row[50], clear_all[51], cursor_col[59:52], cursor_row[67:60],
  // rows_now[76:68], wrap_pending_out[77], zero pad
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic           push;
  tcae_pkg::cmd_t push_cmd;
  logic           q_ready;
  logic           pop;
  logic           q_valid;
  tcae_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  tcae_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_ready   (q_ready)
  );

  tcae_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tcae_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cursor engine. Command words are driven
// directed and at random over several screen settings; a behavioral cursor
// model predicts each result word, which is compared field by field while
// both stream sides idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;

  // the fill cell register sits past the last index the engine decodes
  localparam logic [2:0] REG_FILL_CELL = 3'd5;
  localparam int COL_LIMIT = 256;
  localparam int ROW_LIMIT = 256;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // cell_value[31:0], cell_width[33:32], move_x[43:34], move_y[53:44], zero pad
  logic [55:0] in_tdata;
  // cmd[2:0]
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // cell_write[0], cell_col[8:1], cell_row[16:9], cell_out[48:17], scroll_up[49],
  // grow_row[50], clear_all[51], cursor_col[59:52], cursor_row[67:60],
  // rows_now[76:68], wrap_pending_out[77], zero pad
  logic [79:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  text_cursor_autowrap_engine_core dut (.*);

  // cursor model state and its copy of the registers
  logic        m_auto_wrap;
  logic [1:0]  m_ovf_mode;
  logic [8:0]  m_width_reg;
  logic [8:0]  m_start_h;
  logic [8:0]  m_max_h;
  logic [31:0] m_fill;
  int unsigned cur_col;
  int unsigned cur_row;
  int unsigned row_cnt;
  bit          wrap_pend;
  bit          scroll_hit;
  bit          grow_hit;

  tcae_pkg::res_t pending_results[$];
  int    mismatches;
  bit    idle_on;
  int    hold_cycles;
  string field_name[11] = '{"cell_write", "cell_col", "cell_row", "cell_out", "scroll_up",
                            "grow_row", "clear_all", "cursor_col", "cursor_row", "rows_now",
                            "wrap_pending_out"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned screen_cols();
    return clamp_range(m_width_reg, 2, COL_LIMIT);
  endfunction

  function automatic int unsigned height_cap();
    return clamp_range(m_max_h, 1, ROW_LIMIT);
  endfunction

  function automatic void reset_model();
    m_auto_wrap = 1'b1;
    m_ovf_mode  = tcae_pkg::OVF_WRAP;
    m_width_reg = 9'd80;
    m_start_h   = 9'd25;
    m_max_h     = 9'd25;
    m_fill      = 32'd32;
    cur_col     = 0;
    cur_row     = 0;
    wrap_pend   = 1'b0;
    row_cnt     = clamp_range(m_start_h, 1, ROW_LIMIT);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      tcae_pkg::REG_AUTO_WRAP:     m_auto_wrap = val[0];
      tcae_pkg::REG_OVERFLOW_MODE: m_ovf_mode = val[1:0];
      tcae_pkg::REG_SCREEN_WIDTH:  m_width_reg = val[8:0];
      tcae_pkg::REG_START_HEIGHT: begin
        m_start_h = val[8:0];
        row_cnt   = clamp_range(m_start_h, 1, ROW_LIMIT);
        if (cur_row >= row_cnt) cur_row = row_cnt - 1;
      end
      tcae_pkg::REG_MAX_HEIGHT:    m_max_h = val[8:0];
      REG_FILL_CELL:               m_fill = val;
      default: ;
    endcase
  endfunction

  function automatic void new_line();
    bit can_grow;
    wrap_pend = 1'b0;
    cur_col   = 0;
    if (cur_row + 1 < row_cnt) begin
      cur_row++;
      return;
    end
    can_grow = row_cnt < height_cap();
    case (m_ovf_mode)
      tcae_pkg::OVF_WRAP: cur_row = 0;
      tcae_pkg::OVF_SHIFT: begin
        scroll_hit = 1'b1;
        cur_row    = row_cnt - 1;
      end
      tcae_pkg::OVF_GROW_SHIFT: begin
        if (can_grow) begin
          row_cnt++;
          grow_hit = 1'b1;
        end else begin
          scroll_hit = 1'b1;
        end
        cur_row = row_cnt - 1;
      end
      default: begin
        if (can_grow) begin
          row_cnt++;
          grow_hit = 1'b1;
          cur_row  = row_cnt - 1;
        end else begin
          cur_row = 0;
        end
      end
    endcase
  endfunction

  function automatic tcae_pkg::res_t cursor_predict(logic [2:0] cmd, logic [31:0] cell_val,
                                                    logic [1:0] cw, logic signed [9:0] dx,
                                                    logic signed [9:0] dy);
    tcae_pkg::res_t r;
    int unsigned    w;
    int             tx;
    int             ty;
    int             ax;
    int             ay;
    bit             store;
    r          = '0;
    w          = screen_cols();
    scroll_hit = 1'b0;
    grow_hit   = 1'b0;
    if (cmd == tcae_pkg::CMD_WRITE) begin
      if (cw == 2'd1 || cw == 2'd2) begin
        store = 1'b1;
        // pending wrap and a column left off-screen by a narrower width resolve alike
        if (wrap_pend || cur_col >= w) begin
          if (m_auto_wrap) new_line();
          else cur_col = w - 1;
          wrap_pend = 1'b0;
        end
        if (cur_col == w - 1 && cw == 2'd2) begin
          if (!m_auto_wrap) store = 1'b0;
          else new_line();
        end
        if (store) begin
          r.cell_write = 1'b1;
          r.cell_col   = cur_col[7:0];
          r.cell_row   = cur_row[7:0];
          r.cell_out   = cell_val;
          if (cur_col == w - 1) begin
            wrap_pend = m_auto_wrap;
          end else if (cur_col + cw >= w) begin
            cur_col   = w - 1;
            wrap_pend = m_auto_wrap;
          end else begin
            cur_col = cur_col + cw;
          end
        end
      end
    end else if (cmd == tcae_pkg::CMD_BREAK) begin
      new_line();
    end else if (cmd == tcae_pkg::CMD_MOVE_ABS || cmd == tcae_pkg::CMD_MOVE_REL) begin
      tx = dx;
      ty = dy;
      ax = (tx < 0) ? -tx : tx;
      ay = (ty < 0) ? -ty : ty;
      if (ax <= COL_LIMIT && ay <= ROW_LIMIT && !(tx == 0 && ty == 0)) begin
        wrap_pend = 1'b0;
        if (cmd == tcae_pkg::CMD_MOVE_REL) begin
          tx = tx + int'(cur_col);
          ty = ty + int'(cur_row);
        end
        cur_col = (tx < 0) ? 0 : (tx >= int'(w)) ? w - 1 : tx;
        cur_row = (ty < 0) ? 0 : (ty >= int'(row_cnt)) ? row_cnt - 1 : ty;
      end
    end else if (cmd == tcae_pkg::CMD_CLEAR) begin
      r.clear_all = 1'b1;
      cur_col     = 0;
      cur_row     = 0;
      wrap_pend   = 1'b0;
    end
    r.scroll_up        = scroll_hit;
    r.grow_row         = grow_hit;
    r.cursor_col       = cur_col[7:0];
    r.cursor_row       = cur_row[7:0];
    r.rows_now         = row_cnt[8:0];
    r.wrap_pending_out = wrap_pend;
    return r;
  endfunction

  function automatic logic [31:0] res_field(tcae_pkg::res_t r, int i);
    case (i)
      0:       return 32'(r.cell_write);
      1:       return 32'(r.cell_col);
      2:       return 32'(r.cell_row);
      3:       return r.cell_out;
      4:       return 32'(r.scroll_up);
      5:       return 32'(r.grow_row);
      6:       return 32'(r.clear_all);
      7:       return 32'(r.cursor_col);
      8:       return 32'(r.cursor_row);
      9:       return 32'(r.rows_now);
      default: return 32'(r.wrap_pending_out);
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    tcae_pkg::res_t got;
    tcae_pkg::res_t want;
    bit             bad;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        bad  = 1'b0;
        for (int i = 0; i < 11; i++) begin
          if (res_field(got, i) !== res_field(want, i)) begin
            if (mismatches < 10)
              $display("mismatch %s: expected %0h, got %0h", field_name[i],
                       res_field(want, i), res_field(got, i));
            bad = 1'b1;
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    stall      = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (!idle_on) begin
        out_tready = 1'b1;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall      = pick_gap();
      end
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [31:0] cell_val, logic [1:0] cw,
                           logic signed [9:0] dx, logic signed [9:0] dy);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {2'b00, dy, dx, cw, cell_val};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(cursor_predict(cmd, cell_val, cw, dx, dy));
  endtask

  task automatic move_to(logic [2:0] cmd, logic signed [9:0] dx, logic signed [9:0] dy);
    send_word(cmd, $urandom, 2'd0, dx, dy);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_cfg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // commands weighted toward writes and edges of the screen
  task automatic send_random(int n);
    logic [2:0]        cmd;
    logic [1:0]        cw;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    int                r;
    int unsigned       w;
    repeat (n) begin
      w = screen_cols();
      r = $urandom_range(0, 99);
      if (r < 55) cmd = tcae_pkg::CMD_WRITE;
      else if (r < 70) cmd = tcae_pkg::CMD_BREAK;
      else if (r < 82) cmd = tcae_pkg::CMD_MOVE_ABS;
      else if (r < 92) cmd = tcae_pkg::CMD_MOVE_REL;
      else if (r < 95) cmd = tcae_pkg::CMD_CLEAR;
      else cmd = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 19);
      cw = (r == 0) ? 2'd0 : (r == 1) ? 2'd3 : (r < 7) ? 2'd2 : 2'd1;
      if ($urandom_range(0, 9) == 0) begin
        dx = 10'($urandom);
        dy = 10'($urandom);
      end else if (cmd == tcae_pkg::CMD_MOVE_REL) begin
        dx = 10'($urandom_range(0, 6) - 3);
        dy = 10'($urandom_range(0, 6) - 3);
      end else begin
        dx = ($urandom_range(0, 2) == 0) ? 10'(w - 1) : 10'($urandom_range(0, w + 1));
        dy = ($urandom_range(0, 2) == 0) ? 10'(row_cnt - 1)
                                         : 10'($urandom_range(0, row_cnt + 1));
      end
      send_word(cmd, $urandom, cw, dx, dy);
    end
  endtask

  task automatic run_phase(logic aw, logic [1:0] mode, int width, int sh, int mh, int n,
                           bit idle);
    drain();
    write_reg(tcae_pkg::REG_AUTO_WRAP, 32'(aw));
    write_reg(tcae_pkg::REG_OVERFLOW_MODE, 32'(mode));
    write_reg(tcae_pkg::REG_SCREEN_WIDTH, width);
    write_reg(tcae_pkg::REG_MAX_HEIGHT, mh);
    write_reg(tcae_pkg::REG_START_HEIGHT, sh);
    write_reg(REG_FILL_CELL, $urandom);
    idle_on = idle;
    send_random(n);
  endtask

  // reset settings: writes, wide cells at the edge, move limits, break, clear, unknown codes
  task automatic test_directed();
    idle_on = 1'b1;
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0000, 2'd1, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'hFFFF_FFFF, 2'd1, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'h1234_5678, 2'd0, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'h8765_4321, 2'd3, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'hA5A5_5A5A, 2'd2, 0, 0);
    move_to(tcae_pkg::CMD_MOVE_ABS, 79, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_4E2D, 2'd2, 0, 0);
    move_to(tcae_pkg::CMD_MOVE_ABS, 79, 1);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0041, 2'd1, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0042, 2'd1, 0, 0);
    move_to(tcae_pkg::CMD_MOVE_ABS, -512, -512);
    move_to(tcae_pkg::CMD_MOVE_ABS, 511, 511);
    move_to(tcae_pkg::CMD_MOVE_ABS, 256, 256);
    move_to(tcae_pkg::CMD_MOVE_REL, 0, 0);
    move_to(tcae_pkg::CMD_MOVE_REL, -257, 0);
    move_to(tcae_pkg::CMD_MOVE_REL, -256, -1);
    move_to(tcae_pkg::CMD_MOVE_ABS, 0, 24);
    send_word(tcae_pkg::CMD_BREAK, 0, 0, 0, 0);
    send_word(tcae_pkg::CMD_CLEAR, 0, 0, 0, 0);
    for (int c = 5; c < 8; c++) send_word(3'(c), $urandom, 2'd1, 1, 1);
  endtask

  // no auto-wrap at the edge, a column stranded by a narrower screen, a lower height
  task automatic test_config_edges();
    drain();
    write_reg(tcae_pkg::REG_AUTO_WRAP, 0);
    move_to(tcae_pkg::CMD_MOVE_ABS, 79, 3);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_3042, 2'd2, 0, 0);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0043, 2'd1, 0, 0);
    move_to(tcae_pkg::CMD_MOVE_ABS, 70, 20);
    drain();
    write_reg(tcae_pkg::REG_SCREEN_WIDTH, 10);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0044, 2'd1, 0, 0);
    drain();
    write_reg(tcae_pkg::REG_AUTO_WRAP, 1);
    write_reg(tcae_pkg::REG_SCREEN_WIDTH, 80);
    move_to(tcae_pkg::CMD_MOVE_ABS, 60, 21);
    drain();
    write_reg(tcae_pkg::REG_SCREEN_WIDTH, 10);
    send_word(tcae_pkg::CMD_WRITE, 32'h0000_0045, 2'd1, 0, 0);
    drain();
    write_reg(tcae_pkg::REG_START_HEIGHT, 5);
    send_word(tcae_pkg::CMD_BREAK, 0, 0, 0, 0);
  endtask

  task automatic test_random_settings();
    run_phase(1'b1, tcae_pkg::OVF_WRAP, 80, 25, 25, 200, 1'b1);
    run_phase(1'b1, tcae_pkg::OVF_SHIFT, 2, 1, 1, 180, 1'b1);
    run_phase(1'b0, tcae_pkg::OVF_SHIFT, 256, 256, 256, 200, 1'b0);
    run_phase(1'b1, tcae_pkg::OVF_GROW_SHIFT, 5, 2, 8, 200, 1'b1);
    run_phase(1'b1, tcae_pkg::OVF_GROW_WRAP, 7, 1, 6, 200, 1'b1);
    run_phase(1'b0, tcae_pkg::OVF_GROW_WRAP, 3, 4, 4, 180, 1'b0);
    run_phase(1'b1, tcae_pkg::OVF_GROW_SHIFT, 256, 250, 256, 150, 1'b1);
    // register values past their range clamp inside the engine
    run_phase(1'b1, tcae_pkg::OVF_GROW_WRAP, 0, 0, 511, 120, 1'b1);
    run_phase(1'b0, tcae_pkg::OVF_SHIFT, 300, 400, 0, 120, 1'b1);
  endtask

  // the sink holds off while words keep coming, then the source waits for all results
  task automatic test_backpressure();
    drain();
    idle_on     = 1'b0;
    hold_cycles = 300;
    send_random(260);
    drain();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_on     = 1'b0;
    hold_cycles = 0;
    mismatches  = 0;
    reset_model();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_edges();
    test_random_settings();
    test_backpressure();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcae_pkg.sv
rtl/tcae_front.sv
rtl/tcae_queue.sv
rtl/tcae_back.sv
rtl/text_cursor_autowrap_engine_core.sv
tb/sv/tb_top.sv
